>>> design/smeo_pkg.sv
// shared types and constants of the sliding-mode back-emf observer
package smeo_pkg;

	// sequencer steps, twelve per axis
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VE,    // t = sat(v - e)
		ST_DZ,    // t = sat(t - z), drive term
		ST_MF,    // product F * i_est
		ST_QF,    // q = truncated product
		ST_MG,    // product G * drive
		ST_QG,    // t = truncated product
		ST_IE,    // i_est = sat(q + t)
		ST_ERR,   // new sign code from i_est - i_meas
		ST_ZE,    // t = sat(z_new - e)
		ST_ML,    // product L * t
		ST_QL,    // t = truncated product
		ST_EE,    // e = sat(e + t)
		ST_DONE   // load result register
	} step_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [1:0] {
		REG_STATE_GAIN,
		REG_INPUT_GAIN,
		REG_FILTER_GAIN,
		REG_SLIDE_MAG
	} reg_idx_t;

	// sliding term codes; the fourth code acts as zero
	localparam logic [1:0] SIGN_ZERO   = 2'd0;
	localparam logic [1:0] SIGN_POS    = 2'd1;
	localparam logic [1:0] SIGN_NEG    = 2'd2;
	localparam logic [1:0] SIGN_UNUSED = 2'd3;

	localparam int GAIN_W = 15;
	localparam int MAG_W  = 31;
	localparam int FIELD_W = 32;

	localparam logic [GAIN_W-1:0] STATE_GAIN_RST  = 15'd32322;
	localparam logic [GAIN_W-1:0] INPUT_GAIN_RST  = 15'd2222;
	localparam logic [GAIN_W-1:0] FILTER_GAIN_RST = 15'd6554;
	localparam logic [MAG_W-1:0]  SLIDE_MAG_RST   = 31'd19660800;

	typedef struct packed {
		step_t step;
		logic  axis;      // 0 alpha, 1 beta
		logic  load_out;  // result register takes the new estimates
	} ctrl_t;

endpackage

>>> design/smeo_alu.sv
// shared saturating adder/subtractor with exact sign flags
module smeo_alu #(
	parameter int DW = 32,
	parameter int W  = 33
) (
	input  smeo_pkg::alu_op_t     op,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [DW-1:0]  sat_res,
	output logic                  is_pos,
	output logic                  is_neg
);

	localparam logic signed [W-1:0] SMAX = W'((64'sd1 <<< (DW - 1)) - 64'sd1);
	localparam logic signed [W-1:0] SMIN = -SMAX - W'(1);

	logic signed [W-1:0] exact;

	always_comb begin
		exact = (op == smeo_pkg::ALU_SUB) ? (a - b) : (a + b);
		if (exact > SMAX) begin
			sat_res = SMAX[DW-1:0];
		end else if (exact < SMIN) begin
			sat_res = SMIN[DW-1:0];
		end else begin
			sat_res = exact[DW-1:0];
		end
		is_neg = exact[W-1];
		is_pos = !exact[W-1] && (exact != '0);
	end

endmodule

>>> design/smeo_mul.sv
// shared gain multiplier, registered product, quotient by 2^15 toward zero
module smeo_mul #(
	parameter int DW = 32
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [smeo_pkg::GAIN_W-1:0]          gain,
	input  logic signed [DW-1:0]                 x,
	output logic signed [DW-1:0]                 quo
);

	localparam int PW = DW + smeo_pkg::GAIN_W + 1;

	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] biased;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'($signed({1'b0, gain})) * PW'(x);
		end
	end

	// negative products get 2^15-1 added so the shift rounds toward zero
	always_comb begin
		biased = prod_s1 + (prod_s1[PW-1] ? PW'(32767) : PW'(0));
		quo = biased[DW+smeo_pkg::GAIN_W-1:smeo_pkg::GAIN_W];
	end

endmodule

>>> design/smeo_seq.sv
// step sequencer of the observer
module smeo_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_free,
	output smeo_pkg::ctrl_t  ctrl
);

	smeo_pkg::step_t step_q, step_d;
	logic            axis_q, axis_d;
	logic            load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= smeo_pkg::ST_IDLE;
			axis_q <= 1'b0;
		end else begin
			step_q <= step_d;
			axis_q <= axis_d;
		end
	end

	always_comb begin
		step_d = step_q;
		axis_d = axis_q;
		load   = 1'b0;
		unique case (step_q)
			smeo_pkg::ST_IDLE: begin
				if (in_fire) begin
					step_d = smeo_pkg::ST_VE;
					axis_d = 1'b0;
				end
			end
			smeo_pkg::ST_VE:  step_d = smeo_pkg::ST_DZ;
			smeo_pkg::ST_DZ:  step_d = smeo_pkg::ST_MF;
			smeo_pkg::ST_MF:  step_d = smeo_pkg::ST_QF;
			smeo_pkg::ST_QF:  step_d = smeo_pkg::ST_MG;
			smeo_pkg::ST_MG:  step_d = smeo_pkg::ST_QG;
			smeo_pkg::ST_QG:  step_d = smeo_pkg::ST_IE;
			smeo_pkg::ST_IE:  step_d = smeo_pkg::ST_ERR;
			smeo_pkg::ST_ERR: step_d = smeo_pkg::ST_ZE;
			smeo_pkg::ST_ZE:  step_d = smeo_pkg::ST_ML;
			smeo_pkg::ST_ML:  step_d = smeo_pkg::ST_QL;
			smeo_pkg::ST_QL:  step_d = smeo_pkg::ST_EE;
			smeo_pkg::ST_EE: begin
				if (!axis_q) begin
					axis_d = 1'b1;
					step_d = smeo_pkg::ST_VE;
				end else begin
					step_d = smeo_pkg::ST_DONE;
				end
			end
			smeo_pkg::ST_DONE: begin
				if (out_free) begin
					load   = 1'b1;
					step_d = smeo_pkg::ST_IDLE;
				end
			end
			default: step_d = smeo_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.step     = step_q;
		ctrl.axis     = axis_q;
		ctrl.load_out = load;
	end

endmodule

>>> design/sliding_mode_emf_observer.sv
// top level of the sliding-mode back-emf observer
//
//  channel  | group                 | fields (low bits first)
//  ---------+-----------------------+-------------------------------------------
//  input    | s_tvalid/tready/tdata | v_alpha, v_beta, i_alpha, i_beta
//  result   | m_tvalid/tready/tdata | emf_alpha, emf_beta, cur_alpha_est,
//           |                       | cur_beta_est
//  config   | apb, pready tied high | state_gain, input_gain, filter_gain,
//           |                       | slide_magnitude at 0x0/0x4/0x8/0xc
//
// an item runs 12 steps per axis on the shared adder and the shared gain
// multiplier, then loads the result register and goes back to idle
// s_tready is high only in idle; the result register holds one finished
// transfer, so the block may take the next item while it waits on m_tready
// and stalls in its last step only if that register is still full
// reset clears the estimates, the sliding codes and the gains to defaults
module sliding_mode_emf_observer #(
	parameter int DATA_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // v_alpha, v_beta, i_alpha, i_beta
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // emf_alpha, emf_beta, cur_alpha_est, cur_beta_est
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int FW = smeo_pkg::FIELD_W;
	// operands fit in EW bits, a sum or difference in EW+1
	localparam int EW = (DATA_WIDTH > FW) ? DATA_WIDTH : FW;
	localparam int W  = EW + 1;

	// configuration registers
	logic [smeo_pkg::GAIN_W-1:0] state_gain_q;
	logic [smeo_pkg::GAIN_W-1:0] input_gain_q;
	logic [smeo_pkg::GAIN_W-1:0] filter_gain_q;
	logic [smeo_pkg::MAG_W-1:0]  slide_mag_q;

	// captured input transfer
	logic signed [FW-1:0] v_alpha_q, v_beta_q, i_alpha_q, i_beta_q;

	// observer state, index 0 alpha, 1 beta
	logic signed [DATA_WIDTH-1:0] i_est_q [2];
	logic signed [DATA_WIDTH-1:0] e_est_q [2];
	logic [1:0]                   code_q  [2];

	// working registers
	logic signed [DATA_WIDTH-1:0] t_q;
	logic signed [DATA_WIDTH-1:0] q_q;

	// result register
	logic [4*FW-1:0] out_q;
	logic            m_tvalid_q;

	smeo_pkg::ctrl_t ctrl;
	logic            in_fire;
	logic            out_free;
	logic            cfg_wr;
	logic            ax;

	// shared unit connections
	smeo_pkg::alu_op_t            alu_op;
	logic signed [W-1:0]          alu_a, alu_b;
	logic signed [DATA_WIDTH-1:0] alu_res;
	logic                         alu_pos, alu_neg;
	logic                         mul_en;
	logic [smeo_pkg::GAIN_W-1:0]  mul_gain;
	logic signed [DATA_WIDTH-1:0] mul_x;
	logic signed [DATA_WIDTH-1:0] mul_quo;

	// per-axis selections
	logic signed [FW-1:0]         v_sel, i_sel;
	logic signed [DATA_WIDTH-1:0] i_est_sel, e_est_sel;
	logic [1:0]                   code_sel;

	function automatic logic signed [W-1:0] ext_d(input logic signed [DATA_WIDTH-1:0] x);
		return W'(x);
	endfunction

	function automatic logic signed [W-1:0] ext_f(input logic signed [FW-1:0] x);
		return W'(x);
	endfunction

	function automatic logic [FW-1:0] to_field(input logic signed [DATA_WIDTH-1:0] x);
		logic signed [EW-1:0] wide;
		wide = EW'(x);
		return wide[FW-1:0];
	endfunction

	// sliding term from its sign code
	function automatic logic signed [W-1:0] slide(input logic [1:0] code,
			input logic [smeo_pkg::MAG_W-1:0] mag);
		logic signed [W-1:0] k;
		k = W'($signed({1'b0, mag}));
		if (code == smeo_pkg::SIGN_POS) begin
			return k;
		end else if (code == smeo_pkg::SIGN_NEG) begin
			return -k;
		end
		return '0;
	endfunction

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign ax       = ctrl.axis;

	assign s_tready = (ctrl.step == smeo_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign pready   = 1'b1;

	smeo_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	smeo_alu #(
		.DW (DATA_WIDTH),
		.W  (W)
	) u_alu (
		.op      (alu_op),
		.a       (alu_a),
		.b       (alu_b),
		.sat_res (alu_res),
		.is_pos  (alu_pos),
		.is_neg  (alu_neg)
	);

	smeo_mul #(
		.DW (DATA_WIDTH)
	) u_mul (
		.clk  (clk),
		.en   (mul_en),
		.gain (mul_gain),
		.x    (mul_x),
		.quo  (mul_quo)
	);

	// register read
	always_comb begin
		unique case (smeo_pkg::reg_idx_t'(paddr[3:2]))
			smeo_pkg::REG_STATE_GAIN:  prdata = 32'(state_gain_q);
			smeo_pkg::REG_INPUT_GAIN:  prdata = 32'(input_gain_q);
			smeo_pkg::REG_FILTER_GAIN: prdata = 32'(filter_gain_q);
			smeo_pkg::REG_SLIDE_MAG:   prdata = 32'(slide_mag_q);
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_gain_q  <= smeo_pkg::STATE_GAIN_RST;
			input_gain_q  <= smeo_pkg::INPUT_GAIN_RST;
			filter_gain_q <= smeo_pkg::FILTER_GAIN_RST;
			slide_mag_q   <= smeo_pkg::SLIDE_MAG_RST;
		end else if (cfg_wr) begin
			unique case (smeo_pkg::reg_idx_t'(paddr[3:2]))
				smeo_pkg::REG_STATE_GAIN:  state_gain_q  <= pwdata[smeo_pkg::GAIN_W-1:0];
				smeo_pkg::REG_INPUT_GAIN:  input_gain_q  <= pwdata[smeo_pkg::GAIN_W-1:0];
				smeo_pkg::REG_FILTER_GAIN: filter_gain_q <= pwdata[smeo_pkg::GAIN_W-1:0];
				smeo_pkg::REG_SLIDE_MAG:   slide_mag_q   <= pwdata[smeo_pkg::MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// axis selection
	always_comb begin
		v_sel     = ax ? v_beta_q : v_alpha_q;
		i_sel     = ax ? i_beta_q : i_alpha_q;
		i_est_sel = i_est_q[ax];
		e_est_sel = e_est_q[ax];
		code_sel  = code_q[ax];
	end

	// operand routing for the shared adder and multiplier
	always_comb begin
		alu_op   = smeo_pkg::ALU_SUB;
		alu_a    = ext_d(t_q);
		alu_b    = ext_d(e_est_sel);
		mul_en   = 1'b0;
		mul_gain = state_gain_q;
		mul_x    = t_q;
		unique case (ctrl.step)
			smeo_pkg::ST_VE: begin
				alu_a = ext_f(v_sel);
				alu_b = ext_d(e_est_sel);
			end
			smeo_pkg::ST_DZ: begin
				alu_a = ext_d(t_q);
				alu_b = slide(code_sel, slide_mag_q);
			end
			smeo_pkg::ST_MF: begin
				mul_en   = 1'b1;
				mul_gain = state_gain_q;
				mul_x    = i_est_sel;
			end
			smeo_pkg::ST_MG: begin
				mul_en   = 1'b1;
				mul_gain = input_gain_q;
				mul_x    = t_q;
			end
			smeo_pkg::ST_IE: begin
				alu_op = smeo_pkg::ALU_ADD;
				alu_a  = ext_d(q_q);
				alu_b  = ext_d(t_q);
			end
			smeo_pkg::ST_ERR: begin
				// exact difference, its sign never saturates
				alu_a = ext_d(i_est_sel);
				alu_b = ext_f(i_sel);
			end
			smeo_pkg::ST_ZE: begin
				alu_a = slide(code_sel, slide_mag_q);
				alu_b = ext_d(e_est_sel);
			end
			smeo_pkg::ST_ML: begin
				mul_en   = 1'b1;
				mul_gain = filter_gain_q;
				mul_x    = t_q;
			end
			smeo_pkg::ST_EE: begin
				alu_op = smeo_pkg::ALU_ADD;
				alu_a  = ext_d(e_est_sel);
				alu_b  = ext_d(t_q);
			end
			default: ;
		endcase
	end

	// input capture and working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			v_alpha_q <= s_tdata[FW-1:0];
			v_beta_q  <= s_tdata[2*FW-1:FW];
			i_alpha_q <= s_tdata[3*FW-1:2*FW];
			i_beta_q  <= s_tdata[4*FW-1:3*FW];
		end
		case (ctrl.step) inside
			smeo_pkg::ST_VE, smeo_pkg::ST_DZ, smeo_pkg::ST_ZE: t_q <= alu_res;
			smeo_pkg::ST_QG, smeo_pkg::ST_QL:                  t_q <= mul_quo;
			smeo_pkg::ST_QF:                                   q_q <= mul_quo;
			default: ;
		endcase
		if (ctrl.load_out) begin
			out_q <= {to_field(i_est_q[1]), to_field(i_est_q[0]),
				to_field(e_est_q[1]), to_field(e_est_q[0])};
		end
	end

	// observer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_est_q[0] <= '0;
			i_est_q[1] <= '0;
			e_est_q[0] <= '0;
			e_est_q[1] <= '0;
			code_q[0]  <= smeo_pkg::SIGN_ZERO;
			code_q[1]  <= smeo_pkg::SIGN_ZERO;
		end else begin
			case (ctrl.step)
				smeo_pkg::ST_IE: i_est_q[ax] <= alu_res;
				smeo_pkg::ST_EE: e_est_q[ax] <= alu_res;
				smeo_pkg::ST_ERR: begin
					if (alu_pos) begin
						code_q[ax] <= smeo_pkg::SIGN_POS;
					end else if (alu_neg) begin
						code_q[ax] <= smeo_pkg::SIGN_NEG;
					end else begin
						code_q[ax] <= smeo_pkg::SIGN_ZERO;
					end
				end
				default: ;
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	// an accepted transfer starts the alpha pass at once
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (ctrl.step == smeo_pkg::ST_VE) && !ctrl.axis)
		else $error("accepted transfer did not start the alpha pass");

	// a new result only appears out of the final step
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> (ctrl.step == smeo_pkg::ST_DONE) && ctrl.axis && out_free)
		else $error("result loaded outside the final step or over a pending result");

	// the unused sign code never gets stored
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		(code_q[0] != smeo_pkg::SIGN_UNUSED) && (code_q[1] != smeo_pkg::SIGN_UNUSED))
		else $error("unused sliding code stored");
`endif

endmodule

>>> tb/sv/tb_sliding_mode_emf_observer.sv
`timescale 1ns / 1ps
// self-checking testbench of the sliding-mode back-emf observer
module tb_sliding_mode_emf_observer;
	import smeo_pkg::*;

	localparam longint SIG_MAX = 64'sd2147483647;
	localparam longint SIG_MIN = -64'sd2147483648;
	localparam longint GAIN_ONE = 64'sd32768;   // 1.0 in q1.15
	localparam int PHASES = 8;
	localparam int RANDOM_PER_PHASE = 217;
	localparam int DIRECTED_ITEMS = 16;
	localparam int LONG_HOLD = 300;             // receiver hold-off that fills the block
	localparam int WATCHDOG_LIMIT = 4000;       // cycles without any transfer
	localparam int SETTLE_CYCLES = 30;          // idle time after the last result, before the verdict

	// observer state and gains of its own, one result word per accepted input
	class emf_scoreboard;
		logic [GAIN_W-1:0] f_gain = STATE_GAIN_RST;
		logic [GAIN_W-1:0] g_gain = INPUT_GAIN_RST;
		logic [GAIN_W-1:0] l_gain = FILTER_GAIN_RST;
		logic [MAG_W-1:0] slide_mag = SLIDE_MAG_RST;
		longint cur_est[2] = '{0, 0};
		longint emf_est[2] = '{0, 0};
		logic [1:0] slide_code[2] = '{SIGN_ZERO, SIGN_ZERO};
		logic [127:0] pending_estimates[$];
		int mismatches = 0;

		function void set_register(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_STATE_GAIN: f_gain = value[GAIN_W-1:0];
				REG_INPUT_GAIN: g_gain = value[GAIN_W-1:0];
				REG_FILTER_GAIN: l_gain = value[GAIN_W-1:0];
				REG_SLIDE_MAG: slide_mag = value[MAG_W-1:0];
			endcase
		endfunction

		function longint sat_sig(longint x);
			if (x > SIG_MAX) return SIG_MAX;
			if (x < SIG_MIN) return SIG_MIN;
			return x;
		endfunction

		// exact product, then divide by 2^15 toward zero
		function longint gain_scale(logic [GAIN_W-1:0] g, longint x);
			longint p;
			p = longint'(g) * x;
			return p / GAIN_ONE;
		endfunction

		function longint slide_level(logic [1:0] code);
			case (code)
				SIGN_POS: return longint'(slide_mag);
				SIGN_NEG: return -longint'(slide_mag);
				default: return 0;
			endcase
		endfunction

		// current estimate that the next item on this axis will produce
		function longint next_current(int axis, longint v);
			longint drive;
			drive = sat_sig(sat_sig(v - emf_est[axis]) - slide_level(slide_code[axis]));
			return sat_sig(gain_scale(f_gain, cur_est[axis]) + gain_scale(g_gain, drive));
		endfunction

		function void advance_axis(int axis, longint v, longint i_meas);
			longint ie;
			longint err;
			ie = next_current(axis, v);
			// error taken exactly, so its sign never wraps
			err = ie - i_meas;
			if (err > 0) slide_code[axis] = SIGN_POS;
			else if (err < 0) slide_code[axis] = SIGN_NEG;
			else slide_code[axis] = SIGN_ZERO;
			cur_est[axis] = ie;
			emf_est[axis] = sat_sig(emf_est[axis] +
				gain_scale(l_gain, sat_sig(slide_level(slide_code[axis]) - emf_est[axis])));
		endfunction

		function void note_input(logic [127:0] word);
			logic [127:0] result;
			advance_axis(0, longint'($signed(word[31:0])), longint'($signed(word[95:64])));
			advance_axis(1, longint'($signed(word[63:32])), longint'($signed(word[127:96])));
			result[31:0] = emf_est[0][31:0];
			result[63:32] = emf_est[1][31:0];
			result[95:64] = cur_est[0][31:0];
			result[127:96] = cur_est[1][31:0];
			pending_estimates.push_back(result);
		endfunction

		function void check_result(logic [127:0] word);
			string field_name[4] = '{"emf_alpha", "emf_beta", "cur_alpha_est", "cur_beta_est"};
			logic [127:0] want;
			if (pending_estimates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer %h", word);
				return;
			end
			want = pending_estimates.pop_front();
			for (int f = 0; f < 4; f++) begin
				if (word[32*f +: 32] !== want[32*f +: 32]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch on %s: expected %h, got %h",
							field_name[f], want[32*f +: 32], word[32*f +: 32]);
				end
			end
		endfunction

		function int outstanding();
			return pending_estimates.size();
		endfunction
	endclass

	// every input known from time zero, reset asserted
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;   // v_alpha, v_beta, i_alpha, i_beta
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;        // emf_alpha, emf_beta, cur_alpha_est, cur_beta_est
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	emf_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	sliding_mode_emf_observer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// result side: check each transfer, then choose the next tready
	// a single long hold-off lets the block fill up and stall its input
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (long_hold_req && !long_hold_done) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog: any transfer on either stream restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// apb write: setup cycle, access cycle, register taken at the access edge
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(input logic [127:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		sb.note_input(word);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// gain settings per phase; upper bits of pwdata are junk the block must drop
	task automatic apply_setting(input int phase);
		case (phase)
			1: begin
				// saturation corner: every register at its top
				apb_write(REG_STATE_GAIN, 32'hFFFF_FFFF);
				apb_write(REG_INPUT_GAIN, 32'hFFFF_FFFF);
				apb_write(REG_FILTER_GAIN, 32'hFFFF_FFFF);
				apb_write(REG_SLIDE_MAG, 32'hFFFF_FFFF);
			end
			2: begin
				apb_write(REG_STATE_GAIN, 32'h0);
				apb_write(REG_INPUT_GAIN, 32'h0);
				apb_write(REG_FILTER_GAIN, 32'h0);
				apb_write(REG_SLIDE_MAG, 32'h0);
			end
			4: begin
				// back to nominal motor gains
				apb_write(REG_STATE_GAIN,
					{16'($urandom_range(16'hFFFF, 0)), 1'b0, STATE_GAIN_RST});
				apb_write(REG_INPUT_GAIN,
					{16'($urandom_range(16'hFFFF, 0)), 1'b1, INPUT_GAIN_RST});
				apb_write(REG_FILTER_GAIN,
					{16'($urandom_range(16'hFFFF, 0)), 1'b0, FILTER_GAIN_RST});
				apb_write(REG_SLIDE_MAG, {1'b1, SLIDE_MAG_RST});
			end
			5: begin
				// fast state decay, strong drive
				apb_write(REG_STATE_GAIN, 32'd1);
				apb_write(REG_INPUT_GAIN, 32'd32767);
				apb_write(REG_FILTER_GAIN, $urandom);
				apb_write(REG_SLIDE_MAG, $urandom_range(32'h0400_0000, 0));
			end
			default: begin
				apb_write(REG_STATE_GAIN, $urandom);
				apb_write(REG_INPUT_GAIN, $urandom);
				apb_write(REG_FILTER_GAIN, $urandom);
				if ($urandom_range(1)) apb_write(REG_SLIDE_MAG, $urandom);
				else apb_write(REG_SLIDE_MAG, $urandom_range(32'h0400_0000, 0));
			end
		endcase
	endtask

	// mostly plausible voltages and currents, some full-range and corner values
	function automatic logic [31:0] pick_field(input bit is_current);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) begin
			case ($urandom_range(4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0;
				3: return 32'hFFFF_FFFF;
				default: return 32'h1;
			endcase
		end
		if (r < 28) return $urandom;
		if (is_current) return $urandom_range(32'h0080_0000, 0) - 32'h0040_0000;
		return $urandom_range(32'h0400_0000, 0) - 32'h0200_0000;
	endfunction

	// current that makes the estimate error exactly zero on one axis
	function automatic logic [31:0] zero_error_current(input int axis, input logic [31:0] v);
		longint ie;
		ie = sb.next_current(axis, longint'($signed(v)));
		return ie[31:0];
	endfunction

	function automatic logic [127:0] random_item();
		logic [31:0] va, vb, ia, ib;
		va = pick_field(1'b0);
		vb = pick_field(1'b0);
		ia = ($urandom_range(19) == 0) ? zero_error_current(0, va) : pick_field(1'b1);
		ib = ($urandom_range(19) == 0) ? zero_error_current(1, vb) : pick_field(1'b1);
		return {ib, ia, vb, va};
	endfunction

	// corners of the fields, zero-error items and alternating bit patterns
	function automatic logic [127:0] directed_item(input int n);
		logic [31:0] va, vb, ia, ib;
		va = 32'h0;
		vb = 32'h0;
		ia = 32'h0;
		ib = 32'h0;
		case (n) inside
			1: begin va = 32'h7FFF_FFFF; vb = 32'h7FFF_FFFF; end
			2: begin va = 32'h8000_0000; vb = 32'h8000_0000; end
			3: begin ia = 32'h7FFF_FFFF; ib = 32'h7FFF_FFFF; end
			4: begin ia = 32'h8000_0000; ib = 32'h8000_0000; end
			5: begin va = 32'h7FFF_FFFF; vb = 32'h8000_0000;
				ia = 32'h8000_0000; ib = 32'h7FFF_FFFF; end
			6: begin va = '1; vb = '1; ia = '1; ib = '1; end
			7: begin va = 32'h1; vb = 32'h1; ia = 32'h1; ib = 32'h1; end
			[8:11]: begin
				va = (n == 8) ? 32'h4000_0000 : pick_field(1'b0);
				vb = (n == 8) ? 32'hC000_0000 : pick_field(1'b0);
				ia = (n != 10) ? zero_error_current(0, va) : pick_field(1'b1);
				ib = (n != 9) ? zero_error_current(1, vb) : pick_field(1'b1);
			end
			12, 14: begin va = 32'h5555_5555; vb = 32'hAAAA_AAAA;
				ia = 32'h5555_5555; ib = 32'hAAAA_AAAA; end
			13, 15: begin va = 32'hAAAA_AAAA; vb = 32'h5555_5555;
				ia = 32'hAAAA_AAAA; ib = 32'h5555_5555; end
			default: ;
		endcase
		return {ib, ia, vb, va};
	endfunction

	initial begin
		sb = new;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains, no idling, corners first
		for (int n = 0; n < DIRECTED_ITEMS; n++)
			send_item(directed_item(n));

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_drained();
				apply_setting(phase);
			end
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_idle_pct = 0; end
				1: begin send_idle_pct = 60; recv_idle_pct = 0; end
				2: begin send_idle_pct = 0; recv_idle_pct = 60; end
				default: begin send_idle_pct = 23; recv_idle_pct = 23; end
			endcase
			// sender keeps offering while the receiver holds off
			if (phase == 0)
				long_hold_req = 1'b1;
			for (int k = 0; k < RANDOM_PER_PHASE; k++)
				send_item(random_item());
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
